// File: design/qrt_pkg.sv
// Package for the quorum reply tracker: sizes, codes, entry and result types.
`default_nettype none
package qrt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ID_BITS     = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = ID_BITS + 1;
   localparam int TIME_BITS   = 32;
   localparam int TALLY_BITS  = 2;
   localparam int TYPE_BITS   = 2;
   localparam int TMO_BITS    = 16;
   localparam int KIND_BITS   = 3;
   localparam int OP_BITS     = 2;
   localparam int ADDR_BITS   = 2;
   localparam int DATA_BITS   = 32;

   localparam logic [OP_BITS-1:0] OP_OPEN  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REPLY = 2'd1;
   localparam logic [OP_BITS-1:0] OP_TICK  = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_OPENED  = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_SUCCESS = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_FAIL    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_FULL    = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 3'd4;

   localparam logic [ADDR_BITS-1:0] CSR_TIMEOUT_ADDR = 2'd0;
   localparam logic [TMO_BITS-1:0]  TIMEOUT_RESET    = 16'd20;

   localparam logic [TALLY_BITS-1:0] QUORUM_SUCCESS = 2'd2;
   localparam logic [TALLY_BITS-1:0] QUORUM_REPLIES = 2'd3;
   localparam logic [TALLY_BITS-1:0] FAIL_MAX_SUCC  = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPLY,
      ST_SCAN,
      ST_FLUSH
   } qrt_state_type;

   typedef struct packed {
      logic [TALLY_BITS-1:0] reply_tally;
      logic [TALLY_BITS-1:0] success_tally;
      logic [TYPE_BITS-1:0]  slot_type;
      logic [TIME_BITS-1:0]  open_stamp;
   } qrt_entry_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [ID_BITS-1:0]   result_id;
      logic [TYPE_BITS-1:0] result_type;
   } qrt_result_type;

endpackage
`default_nettype wire

// File: design/quorum_reply_tracker.sv
// Top level of the quorum reply tracker: slot table memory, sequencer and ports.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+----------------------------------------
//  req     | in        | req_valid/req_stall| op, trans_id, op_type, success
//  rsp     | out       | rsp_valid/rsp_stall| kind, result_id, result_type, last
//  csr     | in/out    | APB (pready high)  | timeout_ticks at byte address 0
//
// An item passes through IDLE, which accepts it (open, tick and unknown replies are
// handled there), REPLY for a reply's read-modify-write of its slot entry, SCAN for
// the timeout scan that reads the slot memory one entry per cycle while no held result
// is blocked by rsp_stall, and FLUSH. The slot memory has a single read port.
// Reset clears the open bits, the time counter and the control state; the slot memory
// needs no clearing since only the entries of open slots are used.
// Each result waits in a one-word hold stage so the last flag can be set on the final one.
`default_nettype none
module quorum_reply_tracker (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [qrt_pkg::OP_BITS-1:0]         req_op,
   input  wire  [qrt_pkg::ID_BITS-1:0]         req_trans_id,
   input  wire  [qrt_pkg::TYPE_BITS-1:0]       req_op_type,
   input  wire                                 req_success,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [qrt_pkg::KIND_BITS-1:0]       rsp_kind,
   output logic [qrt_pkg::ID_BITS-1:0]         rsp_result_id,
   output logic [qrt_pkg::TYPE_BITS-1:0]       rsp_result_type,
   output logic                                rsp_last,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [qrt_pkg::ADDR_BITS-1:0]       paddr,
   input  wire  [qrt_pkg::DATA_BITS-1:0]       pwdata,
   output logic [qrt_pkg::DATA_BITS-1:0]       prdata,
   output logic                                pready
);
   import qrt_pkg::*;

   // slot table memory, one entry per slot
   qrt_entry_type entry_mem [TABLE_DEPTH];
   qrt_entry_type mem_q_ff;
   logic          mem_we;
   logic          mem_re;
   logic [ID_BITS-1:0] mem_waddr;
   logic [ID_BITS-1:0] mem_raddr;
   qrt_entry_type mem_wdata;

   // sequencer and table state
   qrt_state_type state_ff, state_in;
   logic [TABLE_DEPTH-1:0] open_ff, open_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [TMO_BITS-1:0]    timeout_ff;
   logic [ID_BITS-1:0]     tid_ff, tid_in;
   logic                   succ_ff, succ_in;
   logic [CNT_BITS-1:0]    scan_cnt_ff, scan_cnt_in;
   logic                   eval_valid_ff, eval_valid_in;
   logic [ID_BITS-1:0]     eval_idx_ff, eval_idx_in;

   // hold stage and output register
   logic           pend_valid_ff, pend_valid_in;
   qrt_result_type pend_ff, pend_in;
   logic           rsp_valid_ff, rsp_valid_in;
   qrt_result_type rsp_word_ff, rsp_word_in;
   logic           rsp_last_ff, rsp_last_in;

   // datapath helpers
   logic                  out_free;
   logic                  free_found;
   logic [ID_BITS-1:0]    free_idx;
   logic [TALLY_BITS-1:0] reply_nx;
   logic [TALLY_BITS-1:0] succ_nx;
   logic [TIME_BITS-1:0]  age;
   logic                  timed_out;
   logic                  do_produce;
   logic                  do_flush;
   qrt_result_type        new_res;
   logic                  csr_write;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      if (paddr == CSR_TIMEOUT_ADDR) begin
         prdata = DATA_BITS'(timeout_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write && paddr == CSR_TIMEOUT_ADDR) begin
         timeout_ff <= pwdata[TMO_BITS-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Slot memory: one write port, one registered read port
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= entry_mem[mem_raddr];
      end
   end

   // ------------------------------------------------------------------
   // Datapath helpers
   // ------------------------------------------------------------------
   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!open_ff[i]) begin
            free_found = 1'b1;
            free_idx   = ID_BITS'(i);
         end
      end
   end

   // reply tallies wrap in two bits
   assign reply_nx = mem_q_ff.reply_tally + TALLY_BITS'(1);
   assign succ_nx  = mem_q_ff.success_tally + TALLY_BITS'(succ_ff);

   // age of the slot under evaluation, modulo the time width
   assign age       = now_ff - mem_q_ff.open_stamp;
   assign timed_out = open_ff[eval_idx_ff] && (age >= TIME_BITS'(timeout_ff));

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         open_ff       <= '0;
         now_ff        <= '0;
         scan_cnt_ff   <= '0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         open_ff       <= open_in;
         now_ff        <= now_in;
         scan_cnt_ff   <= scan_cnt_in;
         eval_valid_ff <= eval_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff      <= tid_in;
      succ_ff     <= succ_in;
      eval_idx_ff <= eval_idx_in;
      pend_ff     <= pend_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      open_in       = open_ff;
      now_in        = now_ff;
      tid_in        = tid_ff;
      succ_in       = succ_ff;
      scan_cnt_in   = scan_cnt_ff;
      eval_valid_in = eval_valid_ff;
      eval_idx_in   = eval_idx_ff;
      mem_we        = 1'b0;
      mem_waddr     = tid_ff;
      mem_wdata     = mem_q_ff;
      mem_re        = 1'b0;
      mem_raddr     = tid_ff;
      do_produce    = 1'b0;
      do_flush      = 1'b0;
      new_res       = '0;
      req_stall     = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            // hold stage is empty here, so a result never blocks
            req_stall = 1'b0;
            if (req_valid) begin
               tid_in      = req_trans_id;
               succ_in     = req_success;
               scan_cnt_in = '0;
               state_in    = ST_SCAN;
               case (req_op)
                  OP_OPEN: begin
                     do_produce = 1'b1;
                     if (free_found) begin
                        open_in[free_idx]       = 1'b1;
                        mem_we                  = 1'b1;
                        mem_waddr               = free_idx;
                        mem_wdata.reply_tally   = '0;
                        mem_wdata.success_tally = '0;
                        mem_wdata.slot_type     = req_op_type;
                        mem_wdata.open_stamp    = now_ff;
                        new_res.kind            = KIND_OPENED;
                        new_res.result_id       = free_idx;
                        new_res.result_type     = req_op_type;
                     end else begin
                        new_res.kind        = KIND_FULL;
                        new_res.result_id   = '0;
                        new_res.result_type = req_op_type;
                     end
                  end
                  OP_REPLY: begin
                     if (open_ff[req_trans_id]) begin
                        // fetch the entry, update it next cycle
                        mem_re    = 1'b1;
                        mem_raddr = req_trans_id;
                        state_in  = ST_REPLY;
                     end else begin
                        do_produce          = 1'b1;
                        new_res.kind        = KIND_UNKNOWN;
                        new_res.result_id   = req_trans_id;
                        new_res.result_type = '0;
                     end
                  end
                  OP_TICK: begin
                     now_in = now_ff + TIME_BITS'(1);
                  end
                  default: begin
                     // unused opcode: no state change, scan still runs
                  end
               endcase
            end
         end

         ST_REPLY: begin
            mem_we                  = 1'b1;
            mem_waddr               = tid_ff;
            mem_wdata.reply_tally   = reply_nx;
            mem_wdata.success_tally = succ_nx;
            new_res.result_id       = tid_ff;
            new_res.result_type     = mem_q_ff.slot_type;
            if (succ_ff && succ_nx == QUORUM_SUCCESS) begin
               open_in[tid_ff] = 1'b0;
               do_produce      = 1'b1;
               new_res.kind    = KIND_SUCCESS;
            end else if (reply_nx == QUORUM_REPLIES && succ_nx <= FAIL_MAX_SUCC) begin
               open_in[tid_ff] = 1'b0;
               do_produce      = 1'b1;
               new_res.kind    = KIND_FAIL;
            end
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            // read one entry per cycle while no held result is blocked, judge the previous one
            if (!(eval_valid_ff && timed_out && pend_valid_ff && !out_free)) begin
               if (eval_valid_ff && timed_out) begin
                  open_in[eval_idx_ff] = 1'b0;
                  do_produce           = 1'b1;
                  new_res.kind         = KIND_FAIL;
                  new_res.result_id    = eval_idx_ff;
                  new_res.result_type  = mem_q_ff.slot_type;
               end
               if (scan_cnt_ff != CNT_BITS'(TABLE_DEPTH)) begin
                  mem_re        = 1'b1;
                  mem_raddr     = scan_cnt_ff[ID_BITS-1:0];
                  eval_valid_in = 1'b1;
                  eval_idx_in   = scan_cnt_ff[ID_BITS-1:0];
                  scan_cnt_in   = scan_cnt_ff + CNT_BITS'(1);
               end else begin
                  eval_valid_in = 1'b0;
                  state_in      = ST_FLUSH;
               end
            end
         end

         ST_FLUSH: begin
            // push the held word out as the last one of this item
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               do_flush = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold stage and output register
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;
      if (do_produce) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = pend_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = new_res;
      end else if (do_flush) begin
         rsp_valid_in  = 1'b1;
         rsp_word_in   = pend_ff;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_word_ff.kind;
   assign rsp_result_id   = rsp_word_ff.result_id;
   assign rsp_result_type = rsp_word_ff.result_type;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // a new item is only taken with an empty hold stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !pend_valid_ff)
      else $error("item accepted while a result is still held");

   // the scan pipeline is drained outside the scan
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FLUSH) |-> !eval_valid_ff)
      else $error("scan evaluation pending outside the scan");

   // scan pointer never runs past the table
   assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= CNT_BITS'(TABLE_DEPTH))
      else $error("scan pointer past the table");

   // leaving flush empties the hold stage
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && state_in == ST_IDLE) |=> !pend_valid_ff)
      else $error("held result left behind after flush");
`endif

endmodule
`default_nettype wire

// File: bench/quorum_reply_tracker_tb.sv
// Self-checking bench for the quorum reply tracker: random and directed words, shadow table.
`default_nettype none
module quorum_reply_tracker_tb;
   import qrt_pkg::*;

   // Opcode 3 is no operation: the block only runs its timeout scan on it.
   localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;
   // Worst case between handshakes is a long receiver hold-off; allow far more than that.
   localparam int IDLE_LIMIT   = 5000;
   // A word with no result may still be in the scan when the last result arrives.
   localparam int SCAN_CYCLES  = 24;
   localparam int LONG_HOLD    = 300;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [ID_BITS-1:0]   trans_id;
      logic [TYPE_BITS-1:0] op_type;
      logic                 success;
   } tracker_req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [ID_BITS-1:0]   result_id;
      logic [TYPE_BITS-1:0] result_type;
      logic                 last;
   } tracker_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [OP_BITS-1:0]    req_op       = OP_TICK;
   logic [ID_BITS-1:0]    req_trans_id = '0;
   logic [TYPE_BITS-1:0]  req_op_type  = '0;
   logic                  req_success  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [KIND_BITS-1:0]  rsp_kind;
   logic [ID_BITS-1:0]    rsp_result_id;
   logic [TYPE_BITS-1:0]  rsp_result_type;
   logic                  rsp_last;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [ADDR_BITS-1:0]  paddr   = '0;
   logic [DATA_BITS-1:0]  pwdata  = '0;
   logic [DATA_BITS-1:0]  prdata;
   logic                  pready;

   quorum_reply_tracker u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_trans_id    (req_trans_id),
      .req_op_type     (req_op_type),
      .req_success     (req_success),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_result_id   (rsp_result_id),
      .rsp_result_type (rsp_result_type),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Words waiting to be driven, and results the shadow table says must come back.
   tracker_req_type pending_words[$];
   tracker_rsp_type expected_results[$];

   // Shadow copy of the slot table, the time counter and the timeout register.
   bit                    slot_live [TABLE_DEPTH];
   logic [TALLY_BITS-1:0] reply_count [TABLE_DEPTH];
   logic [TALLY_BITS-1:0] win_count [TABLE_DEPTH];
   logic [TYPE_BITS-1:0]  slot_op_type [TABLE_DEPTH];
   logic [TIME_BITS-1:0]  slot_stamp [TABLE_DEPTH];
   logic [TIME_BITS-1:0]  tick_count = '0;
   logic [TMO_BITS-1:0]   timeout_reg = TIMEOUT_RESET;

   int  fail_count  = 0;
   int  words_in    = 0;
   int  words_out   = 0;
   int  idle_cycles = 0;
   int  kind_seen [8];
   int  max_burst   = 0;
   int  burst_len   = 0;
   bit  req_took    = 1'b0;
   bit  calm        = 1'b0;
   bit  long_hold_go = 1'b0;
   int  gap_left    = 0;
   int  stall_left  = 0;
   int  hold_left   = 0;

   // Apply one accepted word to the shadow table and queue the results it causes.
   task automatic predict_tracker(input tracker_req_type w);
      tracker_rsp_type      batch[$];
      tracker_rsp_type      r;
      logic [TIME_BITS-1:0] age;
      int                   free_id;
      int                   i;
      free_id = -1;
      r.last  = 1'b0;
      case (w.op)
         OP_OPEN: begin
            for (i = TABLE_DEPTH - 1; i >= 0; i--)
               if (!slot_live[i]) free_id = i;
            r.result_type = w.op_type;
            if (free_id < 0) begin
               r.kind      = KIND_FULL;
               r.result_id = '0;
            end else begin
               slot_live[free_id]    = 1'b1;
               reply_count[free_id]  = '0;
               win_count[free_id]    = '0;
               slot_op_type[free_id] = w.op_type;
               slot_stamp[free_id]   = tick_count;
               r.kind      = KIND_OPENED;
               r.result_id = ID_BITS'(free_id);
            end
            batch.push_back(r);
         end
         OP_REPLY: begin
            r.result_id = w.trans_id;
            if (!slot_live[w.trans_id]) begin
               r.kind        = KIND_UNKNOWN;
               r.result_type = '0;
               batch.push_back(r);
            end else begin
               r.result_type = slot_op_type[w.trans_id];
               reply_count[w.trans_id] = reply_count[w.trans_id] + 1'b1;
               if (w.success)
                  win_count[w.trans_id] = win_count[w.trans_id] + 1'b1;
               // Success wins over the third reply when both land on the same word.
               if (w.success && win_count[w.trans_id] == QUORUM_SUCCESS) begin
                  slot_live[w.trans_id] = 1'b0;
                  r.kind = KIND_SUCCESS;
                  batch.push_back(r);
               end else if (reply_count[w.trans_id] == QUORUM_REPLIES &&
                            win_count[w.trans_id] <= FAIL_MAX_SUCC) begin
                  slot_live[w.trans_id] = 1'b0;
                  r.kind = KIND_FAIL;
                  batch.push_back(r);
               end
            end
         end
         OP_TICK: tick_count = tick_count + 1'b1;
         default: ;
      endcase
      // Timeout scan in ascending slot order; age wraps with the time counter.
      for (i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_live[i]) begin
            age = tick_count - slot_stamp[i];
            if (age >= TIME_BITS'(timeout_reg)) begin
               slot_live[i] = 1'b0;
               if (win_count[i] <= FAIL_MAX_SUCC) begin
                  r.kind        = KIND_FAIL;
                  r.result_id   = ID_BITS'(i);
                  r.result_type = slot_op_type[i];
                  batch.push_back(r);
               end
            end
         end
      end
      if (batch.size() > 0) begin
         batch[batch.size() - 1].last = 1'b1;
         if (batch.size() > max_burst) max_burst = batch.size();
      end
      foreach (batch[k]) expected_results.push_back(batch[k]);
   endtask

   // Sender: advance to the next word once the current one is taken, with random gaps.
   always @(negedge clock) begin : req_driver
      tracker_req_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // hold the stalled word as it is
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
         w = pending_words.pop_front();
         req_op       <= w.op;
         req_trans_id <= w.trans_id;
         req_op_type  <= w.op_type;
         req_success  <= w.success;
         req_valid    <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 16);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: stall in random bursts, plus one long hold-off on request.
   always @(negedge clock) begin : rsp_driver
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (long_hold_go) begin
         long_hold_go = 1'b0;
         hold_left    = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predict on each accepted request word, check each accepted result word.
   always @(posedge clock) begin : monitor
      tracker_req_type w;
      tracker_rsp_type got;
      tracker_rsp_type want;
      bit              rsp_took;
      req_took = 1'b0;
      rsp_took = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            w = '{req_op, req_trans_id, req_op_type, req_success};
            predict_tracker(w);
            words_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_took = 1'b1;
            words_out++;
            got = '{rsp_kind, rsp_result_id, rsp_result_type, rsp_last};
            kind_seen[got.kind]++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("ERROR: unexpected result kind=%0d id=%0d type=%0d last=%0d",
                           got.kind, got.result_id, got.result_type, got.last);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("ERROR: result %0d expected kind=%0d id=%0d type=%0d last=%0d",
                              words_out, want.kind, want.result_id, want.result_type,
                              want.last);
                     $display("       got kind=%0d id=%0d type=%0d last=%0d",
                              got.kind, got.result_id, got.result_type, got.last);
                  end
               end
            end
         end
         idle_cycles = (req_took || rsp_took) ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, expected_results.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic queue_word(input logic [OP_BITS-1:0] op, input int id, input int op_type,
                             input bit success);
      tracker_req_type w;
      w = '{op, id[ID_BITS-1:0], op_type[TYPE_BITS-1:0], success};
      pending_words.push_back(w);
   endtask

   // Build one random word: mostly opens and replies to live slots, some noise.
   task automatic make_word(input int open_pct, output tracker_req_type w);
      int live_ids[$];
      int pick;
      int i;
      w.op       = OP_TICK;
      w.trans_id = ID_BITS'($urandom);
      w.op_type  = TYPE_BITS'($urandom);
      w.success  = 1'($urandom);
      for (i = 0; i < TABLE_DEPTH; i++)
         if (slot_live[i]) live_ids.push_back(i);
      pick = $urandom_range(0, 99);
      if (pick < open_pct) begin
         w.op = OP_OPEN;
      end else if (pick < 85) begin
         // reply to a slot that is open now; fall back to a tick when the table is empty
         if (live_ids.size() > 0) begin
            w.op       = OP_REPLY;
            w.trans_id = ID_BITS'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
         end
      end else if (pick < 91) begin
         w.op = OP_REPLY;
      end else if (pick < 94) begin
         w.op = OP_NONE;
      end
   endtask

   task automatic feed_random(input int count, input int open_pct);
      tracker_req_type w;
      repeat (count) begin
         // keep the queue short so replies track the current table
         while (pending_words.size() >= 2) @(posedge clock);
         make_word(open_pct, w);
         pending_words.push_back(w);
      end
   endtask

   // Wait until every word is taken and every expected result has come back.
   task automatic drain;
      while (pending_words.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
   endtask

   task automatic read_timeout(input logic [TMO_BITS-1:0] want);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_TIMEOUT_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== DATA_BITS'(want)) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("ERROR: timeout register read expected %0d, got %0d", want, prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Program the timeout while idle, then read it back.
   task automatic program_timeout(input logic [TMO_BITS-1:0] value);
      drain();
      repeat (SCAN_CYCLES) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_TIMEOUT_ADDR;
      pwdata  <= DATA_BITS'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      timeout_reg = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      read_timeout(value);
   endtask

   initial begin : stimulus
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         slot_live[i]    = 1'b0;
         reply_count[i]  = '0;
         win_count[i]    = '0;
         slot_op_type[i] = '0;
         slot_stamp[i]   = '0;
      end
      foreach (kind_seen[k]) kind_seen[k] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      read_timeout(TIMEOUT_RESET);

      // Directed, reset timeout: open one slot per operation type.
      for (i = 0; i < 4; i++) queue_word(OP_OPEN, 0, i, 1'b0);
      // two successes decide success
      queue_word(OP_REPLY, 0, 0, 1'b1);
      queue_word(OP_REPLY, 0, 0, 1'b1);
      // three failures decide failure on the third reply
      repeat (3) queue_word(OP_REPLY, 1, 0, 1'b0);
      // one success then two failures still fails
      queue_word(OP_REPLY, 2, 0, 1'b1);
      queue_word(OP_REPLY, 2, 0, 1'b0);
      queue_word(OP_REPLY, 2, 0, 1'b0);
      // second success arriving as the third reply counts as success
      queue_word(OP_REPLY, 3, 0, 1'b0);
      queue_word(OP_REPLY, 3, 3, 1'b1);
      queue_word(OP_REPLY, 3, 0, 1'b1);
      // replies to a never-opened slot and to a freed slot
      queue_word(OP_REPLY, TABLE_DEPTH - 1, 3, 1'b1);
      queue_word(OP_REPLY, 0, 0, 1'b0);
      queue_word(OP_NONE, TABLE_DEPTH - 1, 3, 1'b1);

      // Shortest timeout: single and multiple timeouts on one tick.
      program_timeout(16'd1);
      queue_word(OP_OPEN, 0, 2, 1'b0);
      queue_word(OP_TICK, 0, 0, 1'b0);
      for (i = 0; i < 3; i++) queue_word(OP_OPEN, 0, 3 - i, 1'b0);
      queue_word(OP_TICK, 0, 0, 1'b0);

      // Longest timeout: fill the table and hit table full; hold results off for a while.
      program_timeout(16'hFFFF);
      feed_random(30, 55);
      long_hold_go = 1'b1;
      feed_random(30, 55);

      // Drop to the shortest timeout: the first scan times out every slot opened before the current tick.
      program_timeout(16'd1);
      feed_random(60, 40);

      program_timeout(16'd3);
      feed_random(30, 35);
      // let every result come home before offering more
      drain();
      feed_random(30, 35);

      program_timeout(16'($urandom_range(2, 40)));
      feed_random(60, 40);

      // Quiet tail at the reset timeout: no gaps, no stalls.
      program_timeout(TIMEOUT_RESET);
      calm = 1'b1;
      feed_random(60, 40);

      drain();
      repeat (SCAN_CYCLES) @(posedge clock);
      $display("Summary: %0d request words, %0d result words, largest burst %0d results",
               words_in, words_out, max_burst);
      $display("Results by kind: opened %0d, success %0d, fail %0d, full %0d, unknown %0d",
               kind_seen[KIND_OPENED], kind_seen[KIND_SUCCESS], kind_seen[KIND_FAIL],
               kind_seen[KIND_FULL], kind_seen[KIND_UNKNOWN]);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
